// ----- rtl/lifb_pkg.sv -----
package lifb_pkg;

    localparam int FRAME_BYTES = 14;
    localparam int POS_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_XHEADER = CFG_INDEX_W'(1);

    localparam logic [15:0] HEADER_RESET  = 16'd64;
    localparam logic [7:0]  XHEADER_RESET = 8'd239;

    localparam logic [6:0] SPEED_MAX       = 7'd126;
    localparam logic [7:0] STEPS_128_CODE  = 8'h04;

    // encoded data bytes of one frame taken from the item (parity excluded)
    typedef struct packed {
        logic [7:0] addr_msb;
        logic [7:0] addr_lsb;
        logic [7:0] speed_code;
        logic [7:0] fn_a;
        logic [7:0] fn_b;
        logic [7:0] fn_c;
        logic [7:0] fn_d;
    } t_frame_fields;

    typedef struct packed {
        logic [15:0] header;
        logic [7:0]  xheader;
    } t_cfg;

endpackage

// ----- rtl/loco_info_frame_builder.sv -----
// channel   direction  handshake            word
// input     in         push / full          address, direction, speed, functions
// result    out        empty / pop          one frame byte plus last flag
// config    in         valid / ready        register index and data
//
// each item yields 14 bytes, one per cycle while the result is not stalled; frames
// follow each other with no gap when the next item is already queued
// first byte shows after push passes queue write, serializer load and output register
// synchronous active-low reset empties the queue and output, config to defaults
// input is taken while the item queue has room, even while results stall
module loco_info_frame_builder #(
    parameter int QUEUE_DEPTH = lifb_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [13:0]                      i_loco_address,
    input  logic                             i_direction,
    input  logic [6:0]                       i_speed_step,
    input  logic [28:0]                      i_function_bits,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_frame_byte,
    output logic                             o_last_byte,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lifb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lifb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lifb_pkg::t_frame_fields enc_fields;
    lifb_pkg::t_frame_fields q_data;
    lifb_pkg::t_cfg          cfg;
    logic                    q_empty;
    logic                    q_rd;
    logic [15:0]             r_header;
    logic [7:0]              r_xheader;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= lifb_pkg::HEADER_RESET;
            r_xheader <= lifb_pkg::XHEADER_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lifb_pkg::CFG_HEADER) begin
                r_header <= i_cfg_data[15:0];
            end else if (i_cfg_index == lifb_pkg::CFG_XHEADER) begin
                r_xheader <= i_cfg_data[7:0];
            end
        end
    end

    assign cfg.header  = r_header;
    assign cfg.xheader = r_xheader;

    lifb_front u_front (
        .i_loco_address  (i_loco_address),
        .i_direction     (i_direction),
        .i_speed_step    (i_speed_step),
        .i_function_bits (i_function_bits),
        .o_fields        (enc_fields)
    );

    lifb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (enc_fields),
        .o_full    (full),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_empty   (q_empty)
    );

    lifb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_q_rd       (q_rd),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

// ----- rtl/lifb_front.sv -----
module lifb_front (
    input  logic [13:0]              i_loco_address,
    input  logic                     i_direction,
    input  logic [6:0]               i_speed_step,
    input  logic [28:0]              i_function_bits,
    output lifb_pkg::t_frame_fields  o_fields
);

    logic [6:0] speed_sat;
    logic [6:0] speed_enc;

    always_comb begin
        speed_sat = (i_speed_step > lifb_pkg::SPEED_MAX) ? lifb_pkg::SPEED_MAX : i_speed_step;
        speed_enc = (i_speed_step == 7'd0) ? 7'd0 : speed_sat + 7'd1;
    end

    always_comb begin
        // long addresses carry both top bits set
        o_fields.addr_msb   = {(i_loco_address >= 14'd128) ? 2'b11 : 2'b00,
                               i_loco_address[13:8]};
        o_fields.addr_lsb   = i_loco_address[7:0];
        o_fields.speed_code = {~i_direction, speed_enc};
        o_fields.fn_a       = {3'b000, i_function_bits[0], i_function_bits[4:1]};
        o_fields.fn_b       = i_function_bits[12:5];
        o_fields.fn_c       = i_function_bits[20:13];
        o_fields.fn_d       = i_function_bits[28:21];
    end

endmodule

// ----- rtl/lifb_fifo.sv -----
module lifb_fifo #(
    parameter int DEPTH = lifb_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  lifb_pkg::t_frame_fields i_wr_data,
    output logic                    o_full,
    input  logic                    i_rd,
    output lifb_pkg::t_frame_fields o_rd_data,
    output logic                    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lifb_pkg::t_frame_fields r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/lifb_back.sv -----
module lifb_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lifb_pkg::t_cfg          i_cfg,
    input  logic                    i_q_empty,
    input  lifb_pkg::t_frame_fields i_q_data,
    output logic                    o_q_rd,
    output logic [7:0]              o_frame_byte,
    output logic                    o_last_byte,
    output logic                    o_empty,
    input  logic                    i_pop
);

    localparam int PW = lifb_pkg::POS_W;

    localparam logic [PW-1:0] POS_LEN_LO  = PW'(0);
    localparam logic [PW-1:0] POS_LEN_HI  = PW'(1);
    localparam logic [PW-1:0] POS_HDR_LO  = PW'(2);
    localparam logic [PW-1:0] POS_HDR_HI  = PW'(3);
    localparam logic [PW-1:0] POS_XHEADER = PW'(4);
    localparam logic [PW-1:0] POS_ADR_MSB = PW'(5);
    localparam logic [PW-1:0] POS_ADR_LSB = PW'(6);
    localparam logic [PW-1:0] POS_STEP    = PW'(7);
    localparam logic [PW-1:0] POS_SPEED   = PW'(8);
    localparam logic [PW-1:0] POS_FN_A    = PW'(9);
    localparam logic [PW-1:0] POS_FN_B    = PW'(10);
    localparam logic [PW-1:0] POS_FN_C    = PW'(11);
    localparam logic [PW-1:0] POS_FN_D    = PW'(12);
    localparam logic [PW-1:0] POS_PARITY  = PW'(lifb_pkg::FRAME_BYTES - 1);

    lifb_pkg::t_frame_fields r_cur, n_cur;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_parity, n_parity;
    logic          r_active, n_active;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic [7:0]    byte_sel;
    logic          advance;

    assign advance = !r_out_valid || i_pop;

    always_comb begin
        case (r_pos)
            POS_LEN_LO:  byte_sel = 8'(lifb_pkg::FRAME_BYTES % 256);
            POS_LEN_HI:  byte_sel = 8'(lifb_pkg::FRAME_BYTES / 256);
            POS_HDR_LO:  byte_sel = i_cfg.header[7:0];
            POS_HDR_HI:  byte_sel = i_cfg.header[15:8];
            POS_XHEADER: byte_sel = i_cfg.xheader;
            POS_ADR_MSB: byte_sel = r_cur.addr_msb;
            POS_ADR_LSB: byte_sel = r_cur.addr_lsb;
            POS_STEP:    byte_sel = lifb_pkg::STEPS_128_CODE;
            POS_SPEED:   byte_sel = r_cur.speed_code;
            POS_FN_A:    byte_sel = r_cur.fn_a;
            POS_FN_B:    byte_sel = r_cur.fn_b;
            POS_FN_C:    byte_sel = r_cur.fn_c;
            POS_FN_D:    byte_sel = r_cur.fn_d;
            default:     byte_sel = r_parity;
        endcase
    end

    always_comb begin
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_parity    = r_parity;
        n_active    = r_active;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_q_rd      = 1'b0;
        if (advance) begin
            n_out_valid = 1'b0;
            if (r_active) begin
                n_out_valid = 1'b1;
                n_out_byte  = byte_sel;
                n_out_last  = (r_pos == POS_PARITY);
                if (r_pos == POS_PARITY) begin
                    n_pos    = '0;
                    n_parity = '0;
                    // chain straight into the next frame when one is queued
                    n_active = !i_q_empty;
                    if (!i_q_empty) begin
                        n_cur  = i_q_data;
                        o_q_rd = 1'b1;
                    end
                end else begin
                    n_pos = r_pos + PW'(1);
                    if (r_pos inside {[POS_XHEADER:POS_FN_D]}) begin
                        n_parity = r_parity ^ byte_sel;
                    end
                end
            end else if (!i_q_empty) begin
                n_cur    = i_q_data;
                n_active = 1'b1;
                n_pos    = '0;
                n_parity = '0;
                o_q_rd   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_parity    <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_parity    <= n_parity;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;
    assign o_empty      = !r_out_valid;

endmodule

// ----- rtl/lifb_checker.sv -----
module lifb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_frame_byte,
    input logic       o_last_byte
);

    localparam int PW = lifb_pkg::POS_W;

    // position of the word on the result ports within its frame
    logic [PW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (pop && !empty) begin
            r_cnt <= (r_cnt == PW'(lifb_pkg::FRAME_BYTES - 1)) ? '0 : r_cnt + PW'(1);
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result not empty after reset");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_frame_byte) && $stable(o_last_byte)))
        else $error("stalled result changed");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_byte == (r_cnt == PW'(lifb_pkg::FRAME_BYTES - 1))))
        else $error("last flag out of place");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_cnt == '0) |-> (o_frame_byte == 8'(lifb_pkg::FRAME_BYTES % 256)))
        else $error("frame does not open with its length");

endmodule

bind loco_info_frame_builder lifb_checker u_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lifb_pkg::CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_UNUSED_LO = t_cfg_index'(2);
    localparam t_cfg_index CFG_UNUSED_HI = t_cfg_index'(15);
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [13:0] addr;
        logic        dir;
        logic [6:0]  speed;
        logic [28:0] fn;
    } t_loco;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              full;
    logic [13:0]                       i_loco_address = '0;
    logic                              i_direction = 1'b0;
    logic [6:0]                        i_speed_step = '0;
    logic [28:0]                       i_function_bits = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic [7:0]                        o_frame_byte;
    logic                              o_last_byte;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    t_cfg_index                        i_cfg_index = '0;
    logic [lifb_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    t_loco       pending_locos[$];
    t_frame_word expected_frame_bytes[$];

    logic [15:0] cfg_header = lifb_pkg::HEADER_RESET;
    logic [7:0]  cfg_xheader = lifb_pkg::XHEADER_RESET;
    int          sender_idle_pct = 10;
    int          receiver_idle_pct = 54;
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    loco_info_frame_builder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_loco_address (i_loco_address),
        .i_direction    (i_direction),
        .i_speed_step   (i_speed_step),
        .i_function_bits(i_function_bits),
        .empty          (empty),
        .pop            (pop),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // appends the 14 bytes of the status frame for one locomotive
    function automatic void predict_status_frame(input t_loco loco);
        logic [7:0] frame[lifb_pkg::FRAME_BYTES];
        logic [6:0] spd;
        logic [7:0] parity;
        t_frame_word w;
        spd = (loco.speed > lifb_pkg::SPEED_MAX) ? lifb_pkg::SPEED_MAX : loco.speed;
        frame[0] = 8'(lifb_pkg::FRAME_BYTES);
        frame[1] = 8'(lifb_pkg::FRAME_BYTES >> 8);
        frame[2] = cfg_header[7:0];
        frame[3] = cfg_header[15:8];
        frame[4] = cfg_xheader;
        frame[5] = {2'b00, loco.addr[13:8]} | ((loco.addr >= 14'd128) ? 8'hC0 : 8'h00);
        frame[6] = loco.addr[7:0];
        frame[7] = lifb_pkg::STEPS_128_CODE;
        frame[8] = {~loco.dir, (spd == 7'd0) ? 7'd0 : spd + 7'd1};
        // F0 sits above F4..F1
        frame[9] = {3'b000, loco.fn[0], loco.fn[4:1]};
        frame[10] = loco.fn[12:5];
        frame[11] = loco.fn[20:13];
        frame[12] = loco.fn[28:21];
        parity = 8'h00;
        for (int k = 4; k <= 12; k++) parity ^= frame[k];
        frame[13] = parity;
        for (int k = 0; k < lifb_pkg::FRAME_BYTES; k++) begin
            w.data = frame[k];
            w.last = (k == lifb_pkg::FRAME_BYTES - 1);
            expected_frame_bytes.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin : drive_locos
        t_loco nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_status_frame({i_loco_address, i_direction, i_speed_step,
                                      i_function_bits});
            end
            if (!push || !full) begin
                if (pending_locos.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_locos.pop_front();
                    push <= 1'b1;
                    i_loco_address <= nxt.addr;
                    i_direction <= nxt.dir;
                    i_speed_step <= nxt.speed;
                    i_function_bits <= nxt.fn;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_bytes
        t_frame_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_frame_bytes.size() == 0) begin
                    $error("unexpected word: frame_byte %02h last_byte %0b",
                           o_frame_byte, o_last_byte);
                    mismatch_count++;
                end else begin
                    want = expected_frame_bytes.pop_front();
                    if (o_frame_byte !== want.data) begin
                        $error("frame_byte: expected %02h, got %02h", want.data, o_frame_byte);
                        mismatch_count++;
                    end
                    if (o_last_byte !== want.last) begin
                        $error("last_byte: expected %0b, got %0b", want.last, o_last_byte);
                        mismatch_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ends the run if no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[loco_info_frame_builder] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_loco(input logic [13:0] addr, input logic dir,
                            input logic [6:0] speed, input logic [28:0] fn);
        pending_locos.push_back({addr, dir, speed, fn});
    endtask

    task automatic write_register(input t_cfg_index idx,
                                  input logic [lifb_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lifb_pkg::CFG_HEADER:  cfg_header = data;
            lifb_pkg::CFG_XHEADER: cfg_xheader = data[7:0];
            default:               ;
        endcase
    endtask

    // sampled away from the rising edge so the driver has settled
    task automatic wait_frames_done();
        while (pending_locos.size() != 0 || push) @(negedge i_clk);
        while (expected_frame_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_locos(input int count);
        logic [13:0] addr;
        logic [6:0]  speed;
        for (int n = 0; n < count; n++) begin
            // short addresses often, to hit both address encodings
            addr = ($urandom_range(2) == 0) ? 14'($urandom_range(255))
                                             : 14'($urandom_range(16383));
            case ($urandom_range(9))
                0:       speed = 7'd0;
                1:       speed = 7'd127;
                2:       speed = lifb_pkg::SPEED_MAX;
                default: speed = 7'($urandom_range(127));
            endcase
            add_loco(addr, 1'($urandom_range(1)), speed, 29'($urandom()));
        end
        wait_frames_done();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, extremes of every field
        add_loco(14'd0, 1'b0, 7'd0, 29'd0);
        add_loco(14'd16383, 1'b1, 7'd126, 29'h1FFFFFFF);
        add_loco(14'd127, 1'b0, 7'd1, 29'h00000001);
        add_loco(14'd128, 1'b1, 7'd127, 29'h00000002);
        add_loco(14'd129, 1'b0, 7'd125, 29'h00000010);
        add_loco(14'd255, 1'b1, 7'd2, 29'h00000020);
        add_loco(14'd256, 1'b0, 7'd64, 29'h00001000);
        add_loco(14'h2AAA, 1'b1, 7'h55, 29'h00002000);
        add_loco(14'h1555, 1'b0, 7'h2A, 29'h00100000);
        add_loco(14'd1, 1'b1, 7'd0, 29'h00200000);
        add_loco(14'd3, 1'b0, 7'd127, 29'h10000000);
        add_loco(14'h3F00, 1'b1, 7'd100, 29'h0AAAAAAA);
        add_loco(14'h00FF, 1'b0, 7'd63, 29'h15555555);
        add_loco(14'h2000, 1'b1, 7'd1, 29'h0000001F);
        add_loco(14'd16383, 1'b0, 7'd127, 29'h1FFFFFE0);
        add_loco(14'd0, 1'b1, 7'd126, 29'd0);
        wait_frames_done();

        // extremes; writes beyond the register list must change nothing
        write_register(lifb_pkg::CFG_HEADER, 16'hFFFF);
        write_register(lifb_pkg::CFG_XHEADER, 16'hAB00);
        write_register(CFG_UNUSED_LO, 16'h1234);
        write_register(CFG_UNUSED_HI, 16'hFFFF);
        add_loco(14'd128, 1'b0, 7'd127, 29'h1FFFFFFF);
        add_loco(14'd127, 1'b1, 7'd0, 29'd0);
        run_random_locos(30);

        sender_idle_pct = 54;
        receiver_idle_pct = 10;
        write_register(lifb_pkg::CFG_HEADER, 16'h0000);
        write_register(lifb_pkg::CFG_XHEADER, 16'h12FF);
        run_random_locos(31);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_register(lifb_pkg::CFG_HEADER, 16'($urandom()));
        write_register(lifb_pkg::CFG_XHEADER, 16'($urandom()));
        run_random_locos(31);

        if (mismatch_count == 0 && expected_frame_bytes.size() == 0) begin
            $display("[loco_info_frame_builder] OK");
        end else begin
            $display("[loco_info_frame_builder] ERROR");
        end
        $finish;
    end

endmodule
